/* rtl/assert_macros.svh */
// Assertion helpers for the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

  localparam int WHOLE_W = 48;
  localparam int FRAC_W  = 32;
  localparam int OUT_W   = WHOLE_W + 2 * FRAC_W;

  // Result payload of a zero result or an error: whole 0, numerator 0, denominator 1.
  localparam logic [OUT_W-1:0] TRIVIAL_RES = {FRAC_W'(1), FRAC_W'(0), WHOLE_W'(0)};

endpackage
`default_nettype wire

/* rtl/mixed_fraction_alu.sv */
// Channel  Dir  tdata fields (low bit up)                           tuser
// in_      in   left_whole, left_numer, left_denom, right_whole,    op
//               right_numer, right_denom (OPERAND_BITS each)
// out_     out  res_whole[47:0], res_numer[31:0], res_denom[31:0]   error
//
// A request runs the binary GCD steps, then three divisions on the shared divider, each
// over MW quotient bits, with MW = 6*OPERAND_BITS+4 (52 at the default). An error or
// zero result skips the GCD steps and the divisions.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
// in_tready is high only while idle; a finished result waits in the sequencer
// until the output register is free, so a stalled out_ side holds off new requests.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mixed_fraction_alu #(
  parameter int OPERAND_BITS = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  // left_whole, left_numer, left_denom, right_whole, right_numer, right_denom
  input  wire  [((6*OPERAND_BITS+7)/8)*8-1:0] in_tdata,
  // op
  input  wire  mfa_pkg::op_t          in_tuser,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // res_whole, res_numer, res_denom
  output logic [mfa_pkg::OUT_W-1:0]   out_tdata,
  // error
  output logic                        out_tuser
);
  import mfa_pkg::*;

  localparam int N  = OPERAND_BITS;
  localparam int TW = 2 * N + 2;      // whole*denom + numer, signed
  localparam int VW = 3 * N + 2;      // operand over the common denominator, signed
  localparam int MW = 2 * VW;         // widest magnitude (product of two operands)
  localparam int CW = $clog2(MW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROD  = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_COMB  = 4'd3;
  localparam logic [3:0] S_SIGN  = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  // Which of the three divisions the shared divider is running.
  localparam logic [1:0] PH_MAG = 2'd0;  // magnitude / gcd
  localparam logic [1:0] PH_DEN = 2'd1;  // denominator / gcd
  localparam logic [1:0] PH_Q   = 2'd2;  // reduced magnitude / reduced denominator

  logic [3:0]           st_r, st_nxt;
  op_t                  op_r, op_nxt;
  logic signed [N-1:0]  lw_r, lw_nxt, rw_r, rw_nxt;
  logic [N-1:0]         ln_r, ln_nxt, ld_r, ld_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic signed [TW-1:0] lt_r, lt_nxt, rt_r, rt_nxt;
  logic [2*N-1:0]       den0_r, den0_nxt;
  logic signed [VW-1:0] lv_r, lv_nxt, rv_r, rv_nxt;
  logic signed [MW-1:0] y_r, y_nxt;
  logic [MW-1:0]        den_r, den_nxt, mag_r, mag_nxt;
  logic                 neg_r, neg_nxt, err_r, err_nxt, triv_r, triv_nxt;
  logic [MW-1:0]        ga_r, ga_nxt, gb_r, gb_nxt;
  logic [CW-1:0]        gk_r, gk_nxt;
  logic [MW-1:0]        dq_r, dq_nxt, dr_r, dr_nxt, dd_r, dd_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [1:0]           ph_r, ph_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt, out_tuser_r, out_tuser_nxt;
  logic [OUT_W-1:0]     out_tdata_r, out_tdata_nxt;

  // Operand expansion terms.
  logic signed [TW-1:0] lwx, ldx, lnx, rwx, rdx_t, rnx;
  logic signed [VW-1:0] ltx, rtx, ldv, rdv;
  logic signed [VW-1:0] rv_abs;
  logic signed [MW-1:0] y_abs;

  // Shared divider step: one compare and subtract a cycle.
  logic [MW:0]   dv_t, dv_sub;
  logic          dv_ge;
  logic [MW-1:0] dv_rem, dv_quo;
  logic          dv_last;

  // GCD step.
  logic [MW-1:0] g_diff_ab, g_diff_ba, g_val;

  // Final packing.
  logic [MW+WHOLE_W-1:0] qx, qs;
  logic [MW+FRAC_W-1:0]  nx, dx;

  always_comb begin
    lwx   = TW'(lw_r);
    ldx   = TW'($signed({1'b0, ld_r}));
    lnx   = lw_r[N-1] ? -TW'($signed({1'b0, ln_r})) : TW'($signed({1'b0, ln_r}));
    rwx   = TW'(rw_r);
    rdx_t = TW'($signed({1'b0, rd_r}));
    rnx   = rw_r[N-1] ? -TW'($signed({1'b0, rn_r})) : TW'($signed({1'b0, rn_r}));
    ltx   = VW'(lt_r);
    rtx   = VW'(rt_r);
    ldv   = VW'($signed({1'b0, ld_r}));
    rdv   = VW'($signed({1'b0, rd_r}));
    rv_abs = rv_r[VW-1] ? -rv_r : rv_r;
    y_abs  = y_r[MW-1] ? -y_r : y_r;

    dv_t    = {dr_r, dq_r[MW-1]};
    dv_sub  = dv_t - {1'b0, dd_r};
    dv_ge   = (dv_t >= {1'b0, dd_r});
    dv_rem  = dv_ge ? dv_sub[MW-1:0] : dv_t[MW-1:0];
    dv_quo  = {dq_r[MW-2:0], dv_ge};
    dv_last = (cnt_r == CW'(MW - 1));

    g_diff_ab = ga_r - gb_r;
    g_diff_ba = gb_r - ga_r;
    g_val     = ((gb_r == '0) ? ga_r : gb_r) << gk_r;

    // A negative result keeps its sign only in the whole part.
    qx = {{WHOLE_W{1'b0}}, dq_r};
    qs = neg_r ? -qx : qx;
    nx = {{FRAC_W{1'b0}}, dr_r};
    dx = {{FRAC_W{1'b0}}, den_r};
  end

  always_comb begin
    st_nxt = st_r;   op_nxt = op_r;
    lw_nxt = lw_r;   ln_nxt = ln_r;   ld_nxt = ld_r;
    rw_nxt = rw_r;   rn_nxt = rn_r;   rd_nxt = rd_r;
    lt_nxt = lt_r;   rt_nxt = rt_r;   den0_nxt = den0_r;
    lv_nxt = lv_r;   rv_nxt = rv_r;   y_nxt = y_r;
    den_nxt = den_r; mag_nxt = mag_r;
    neg_nxt = neg_r; err_nxt = err_r; triv_nxt = triv_r;
    ga_nxt = ga_r;   gb_nxt = gb_r;   gk_nxt = gk_r;
    dq_nxt = dq_r;   dr_nxt = dr_r;   dd_nxt = dd_r;
    cnt_nxt = cnt_r; ph_nxt = ph_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser;
          lw_nxt = $signed(in_tdata[0*N +: N]);
          ln_nxt = in_tdata[1*N +: N];
          ld_nxt = in_tdata[2*N +: N];
          rw_nxt = $signed(in_tdata[3*N +: N]);
          rn_nxt = in_tdata[4*N +: N];
          rd_nxt = in_tdata[5*N +: N];
          st_nxt = S_PROD;
        end
      end
      S_PROD: begin
        // Improper numerators; a negative whole part negates the fraction.
        lt_nxt   = TW'(lwx * ldx) + lnx;
        rt_nxt   = TW'(rwx * rdx_t) + rnx;
        den0_nxt = ld_r * rd_r;
        st_nxt   = S_SCALE;
      end
      S_SCALE: begin
        // Bring both operands over ld * rd.
        lv_nxt  = VW'(ltx * rdv);
        rv_nxt  = VW'(rtx * ldv);
        den_nxt = (op_r == OP_MUL) ? MW'(den0_r * den0_r) : MW'(den0_r);
        st_nxt  = S_COMB;
      end
      S_COMB: begin
        case (op_r)
          OP_ADD:  y_nxt = MW'(lv_r) + MW'(rv_r);
          OP_SUB:  y_nxt = MW'(lv_r) - MW'(rv_r);
          OP_MUL:  y_nxt = MW'(lv_r) * MW'(rv_r);
          default: begin
            y_nxt   = MW'(lv_r);
            den_nxt = MW'($unsigned(rv_abs));
          end
        endcase
        st_nxt = S_SIGN;
      end
      S_SIGN: begin
        err_nxt  = (ld_r == '0) || (rd_r == '0) || ((op_r == OP_DIV) && (rv_r == '0));
        neg_nxt  = y_r[MW-1] ^ ((op_r == OP_DIV) && rv_r[VW-1]);
        mag_nxt  = $unsigned(y_abs);
        triv_nxt = err_nxt || (y_r == '0);
        ga_nxt   = $unsigned(y_abs);
        gb_nxt   = den_r;
        gk_nxt   = '0;
        st_nxt   = triv_nxt ? S_DONE : S_GCD;
      end
      S_GCD: begin
        // Binary GCD: one shift or one subtract per cycle.
        if (ga_r == '0 || gb_r == '0) begin
          dq_nxt  = mag_r;
          dr_nxt  = '0;
          dd_nxt  = g_val;
          cnt_nxt = '0;
          ph_nxt  = PH_MAG;
          st_nxt  = S_DIV;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          gk_nxt = gk_r + CW'(1);
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (ga_r >= gb_r) begin
          ga_nxt = g_diff_ab >> 1;
        end else begin
          gb_nxt = g_diff_ba >> 1;
        end
      end
      S_DIV: begin
        dq_nxt  = dv_quo;
        dr_nxt  = dv_rem;
        cnt_nxt = cnt_r + CW'(1);
        if (dv_last) begin
          cnt_nxt = '0;
          dr_nxt  = '0;
          case (ph_r)
            PH_MAG: begin
              mag_nxt = dv_quo;
              dq_nxt  = den_r;
              ph_nxt  = PH_DEN;
            end
            PH_DEN: begin
              den_nxt = dv_quo;
              dq_nxt  = mag_r;
              dd_nxt  = dv_quo;
              ph_nxt  = PH_Q;
            end
            default: begin
              dq_nxt = dv_quo;
              dr_nxt = dv_rem;
              if (dv_rem == '0) begin
                den_nxt = MW'(1);
              end
              st_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = err_r;
          out_tdata_nxt  = triv_r ? TRIVIAL_RES
                                  : {dx[FRAC_W-1:0], nx[FRAC_W-1:0], qs[WHOLE_W-1:0]};
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r <= op_nxt;
    lw_r <= lw_nxt;  ln_r <= ln_nxt;  ld_r <= ld_nxt;
    rw_r <= rw_nxt;  rn_r <= rn_nxt;  rd_r <= rd_nxt;
    lt_r <= lt_nxt;  rt_r <= rt_nxt;  den0_r <= den0_nxt;
    lv_r <= lv_nxt;  rv_r <= rv_nxt;  y_r <= y_nxt;
    den_r <= den_nxt; mag_r <= mag_nxt;
    neg_r <= neg_nxt; err_r <= err_nxt; triv_r <= triv_nxt;
    ga_r <= ga_nxt;  gb_r <= gb_nxt;  gk_r <= gk_nxt;
    dq_r <= dq_nxt;  dr_r <= dr_nxt;  dd_r <= dd_nxt;
    cnt_r <= cnt_nxt; ph_r <= ph_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `MFA_ASSERT_IMP(a_err_payload, out_tvalid && out_tuser, out_tdata == TRIVIAL_RES, "bad error")
  `MFA_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "still ready")
  `MFA_ASSERT_IMP(a_gcd_live, st_r == S_GCD, (ga_r != '0) || (gb_r != '0), "gcd operands zero")

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for mixed_fraction_alu. The directed requests come first:
// operand extremes, every operation, zero denominators, a zero divisor, zero
// results, negative results below one and numerators not below their denominator.
// Random requests follow. A behavioral predictor computes each expected result.
// Both stream sides idle and stall at random.
module tb;
  import mfa_pkg::*;

  typedef struct packed {
    op_t              op;
    logic signed [7:0] lw;
    logic [7:0]        ln;
    logic [7:0]        ld;
    logic signed [7:0] rw;
    logic [7:0]        rn;
    logic [7:0]        rd;
  } frac_req_t;

  typedef struct packed {
    logic [47:0] whole;
    logic [31:0] numer;
    logic [31:0] denom;
    logic        err;
  } frac_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  op_t         in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic        out_tuser;

  frac_req_t   pending_reqs[$];
  frac_res_t   expected_results[$];
  frac_req_t   req_on_bus;
  int          in_gap;
  int          out_gap;
  int          errors;
  int          results_checked;
  int          zero_flagged;

  mixed_fraction_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Euclid's algorithm on the magnitudes.
  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    if (a < b) begin
      t = a; a = b; b = t;
    end
    while (b != 0) begin
      t = a % b; a = b; b = t;
    end
    return a;
  endfunction

  // Reduced mixed-number result of one request.
  function automatic frac_res_t reduce_fraction(frac_req_t q);
    frac_res_t r;
    longint lwv, lnv, ldv, rwv, rnv, rdv, lv, rv, y;
    longint unsigned mag, den, g, quot, rem;
    logic neg;
    r = '{whole: '0, numer: '0, denom: 32'd1, err: 1'b0};
    lwv = longint'(q.lw); lnv = longint'(q.ln); ldv = longint'(q.ld);
    rwv = longint'(q.rw); rnv = longint'(q.rn); rdv = longint'(q.rd);
    y = 0;
    if (ldv == 0 || rdv == 0) begin
      r.err = 1'b1;
      return r;
    end
    // A negative whole part makes the whole fraction negative.
    if (lwv < 0) lnv = -lnv;
    if (rwv < 0) rnv = -rnv;
    lv = (lwv * ldv + lnv) * rdv;
    rv = (rwv * rdv + rnv) * ldv;
    den = ldv * rdv;
    case (q.op)
      OP_ADD: y = lv + rv;
      OP_SUB: y = lv - rv;
      OP_MUL: begin
        y = lv * rv;
        den = den * den;
      end
      default: y = 0;
    endcase
    if (q.op == OP_DIV) begin
      if (rv == 0) begin
        r.err = 1'b1;
        return r;
      end
      // Equal signs give a positive quotient.
      neg = (lv < 0 && rv > 0) || (lv > 0 && rv < 0);
      mag = (lv < 0) ? -lv : lv;
      den = (rv < 0) ? -rv : rv;
    end else begin
      neg = y < 0;
      mag = (y < 0) ? -y : y;
    end
    if (mag == 0) return r;
    g = gcd_of(mag, den);
    mag = mag / g;
    den = den / g;
    quot = mag / den;
    rem = mag % den;
    if (rem == 0) den = 1;
    // The sign lives in the whole part only, so it is lost below one.
    r.whole = neg ? 48'(-quot) : 48'(quot);
    r.numer = rem[31:0];
    r.denom = den[31:0];
    return r;
  endfunction

  function automatic frac_req_t make_req(op_t op, int lw, int ln, int ld,
                                         int rw, int rn, int rd);
    frac_req_t q;
    q.op = op; q.lw = lw[7:0]; q.ln = ln[7:0]; q.ld = ld[7:0];
    q.rw = rw[7:0]; q.rn = rn[7:0]; q.rd = rd[7:0];
    return q;
  endfunction

  // Driver: the expectation is queued at the edge where the request is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (in_tvalid && in_tready) begin
      expected_results.push_back(reduce_fraction(req_on_bus));
      in_tvalid <= 1'b0;
      in_gap <= pick_gap();
    end else if (!in_tvalid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        req_on_bus = pending_reqs.pop_front();
        in_tdata <= {req_on_bus.rd, req_on_bus.rn, req_on_bus.rw,
                     req_on_bus.ld, req_on_bus.ln, req_on_bus.lw};
        in_tuser <= req_on_bus.op;
        in_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: random backpressure, every result checked against the oldest expectation.
  always @(posedge clk) begin
    frac_res_t got;
    frac_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{whole: out_tdata[47:0], numer: out_tdata[79:48],
                denom: out_tdata[111:80], err: out_tuser};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result whole=%0d numer=%0d denom=%0d error=%0b",
                   $time, $signed(got.whole), got.numer, got.denom, got.err);
          errors++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.err || want.whole == 0) zero_flagged++;
          if (got.whole !== want.whole) begin
            $display("%0t: res_whole expected %0d actual %0d", $time,
                     $signed(want.whole), $signed(got.whole));
            errors++;
          end
          if (got.numer !== want.numer) begin
            $display("%0t: res_numer expected %0d actual %0d", $time, want.numer, got.numer);
            errors++;
          end
          if (got.denom !== want.denom) begin
            $display("%0t: res_denom expected %0d actual %0d", $time, want.denom, got.denom);
            errors++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error expected %0b actual %0b", $time, want.err, got.err);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) out_gap <= pick_gap();
      end
    end
  end

  initial begin
    frac_req_t q;
    int k;
    errors = 0;
    results_checked = 0;
    zero_flagged = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    out_tready = 1'b0;

    // Directed requests.
    pending_reqs.push_back(make_req(OP_ADD, 1, 1, 2, 2, 1, 3));
    pending_reqs.push_back(make_req(OP_SUB, 1, 1, 2, 2, 1, 3));
    pending_reqs.push_back(make_req(OP_MUL, -3, 1, 4, 2, 2, 5));
    pending_reqs.push_back(make_req(OP_DIV, -3, 1, 4, -2, 2, 5));
    pending_reqs.push_back(make_req(OP_DIV, 3, 1, 4, -2, 2, 5));
    pending_reqs.push_back(make_req(OP_ADD, 127, 255, 255, 127, 255, 255));
    pending_reqs.push_back(make_req(OP_SUB, -128, 255, 255, 127, 255, 255));
    pending_reqs.push_back(make_req(OP_MUL, -128, 255, 255, -128, 255, 255));
    pending_reqs.push_back(make_req(OP_MUL, 127, 255, 1, -128, 0, 1));
    pending_reqs.push_back(make_req(OP_DIV, 127, 255, 255, 0, 1, 255));
    pending_reqs.push_back(make_req(OP_DIV, -128, 0, 1, 0, 1, 255));
    pending_reqs.push_back(make_req(OP_ADD, 1, 1, 0, 1, 1, 2));
    pending_reqs.push_back(make_req(OP_MUL, 1, 1, 2, 1, 1, 0));
    pending_reqs.push_back(make_req(OP_DIV, 5, 3, 7, 0, 0, 9));
    pending_reqs.push_back(make_req(OP_SUB, 2, 1, 3, 2, 1, 3));
    pending_reqs.push_back(make_req(OP_MUL, 0, 0, 5, 7, 3, 4));
    pending_reqs.push_back(make_req(OP_SUB, 0, 1, 3, 0, 2, 3));
    pending_reqs.push_back(make_req(OP_ADD, -1, 2, 3, 1, 0, 1));
    pending_reqs.push_back(make_req(OP_ADD, 0, 200, 3, 0, 255, 7));
    pending_reqs.push_back(make_req(OP_DIV, 0, 250, 1, 0, 255, 2));
    pending_reqs.push_back(make_req(OP_SUB, -128, 0, 128, 127, 128, 127));

    // Random requests: a small share has a zero denominator or a zero divisor,
    // another share uses only small values so that reductions cancel a lot.
    for (k = 0; k < 1630; k++) begin
      q.op = op_t'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        q.lw = 8'($signed($urandom_range(0, 8)) - 4);
        q.ln = 8'($urandom_range(0, 6));
        q.ld = 8'($urandom_range(1, 8));
        q.rw = 8'($signed($urandom_range(0, 8)) - 4);
        q.rn = 8'($urandom_range(0, 6));
        q.rd = 8'($urandom_range(1, 8));
      end else begin
        q.lw = 8'($urandom_range(0, 255));
        q.ln = 8'($urandom_range(0, 255));
        q.ld = 8'($urandom_range(1, 255));
        q.rw = 8'($urandom_range(0, 255));
        q.rn = 8'($urandom_range(0, 255));
        q.rd = 8'($urandom_range(1, 255));
      end
      case ($urandom_range(0, 39))
        0: q.ld = 8'd0;
        1: q.rd = 8'd0;
        2: begin
          q.rw = 8'sd0;
          q.rn = 8'd0;
        end
        default: ;
      endcase
      pending_reqs.push_back(q);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Checked %0d results over all four operations, %0d of them zero-whole or error.",
             results_checked, zero_flagged);
    if (errors == 0) begin
      $display("PASS mixed_fraction_alu");
    end else begin
      $display("FAIL mixed_fraction_alu");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("FAIL mixed_fraction_alu");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/mfa_pkg.sv
rtl/mixed_fraction_alu.sv
bench/tb.sv
